// ===== hdl/wcc_pkg.sv =====
// ----------------------------------------------------------------------------
// wcc_pkg
// Shared widths, codes and types of the window color classifier.
// ----------------------------------------------------------------------------
package wcc_pkg;

  localparam int unsigned ValueWidth  = 8;
  localparam int unsigned RowWidth    = 6;
  localparam int unsigned CountWidth  = 14;
  localparam int unsigned ClassWidth  = 3;
  localparam int unsigned ApbAddrWidth = 4;
  localparam int unsigned ApbDataWidth = 32;

  localparam logic [CountWidth-1:0] TallyMax = {CountWidth{1'b1}};

  // Reset values of the configuration registers
  localparam logic [ValueWidth-1:0] ChannelThresholdReset = ValueWidth'(100);
  localparam logic [CountWidth-1:0] CountThresholdReset   = CountWidth'(100);
  localparam logic [RowWidth-1:0]   WindowFirstRowReset   = RowWidth'(55);
  localparam logic [RowWidth-1:0]   WindowLastRowReset    = RowWidth'(63);

  typedef enum logic [ClassWidth-1:0] {
    CLASS_NONE  = 3'd0,
    CLASS_RED   = 3'd1,
    CLASS_GREEN = 3'd2,
    CLASS_BLUE  = 3'd3,
    CLASS_ROBOT = 3'd4
  } color_class_t;

  typedef enum logic [1:0] {
    REG_CHANNEL_THRESHOLD = 2'd0,
    REG_COUNT_THRESHOLD   = 2'd1,
    REG_WINDOW_FIRST_ROW  = 2'd2,
    REG_WINDOW_LAST_ROW   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [ValueWidth-1:0] channel_threshold;
    logic [CountWidth-1:0] count_threshold;
    logic [RowWidth-1:0]   window_first_row;
    logic [RowWidth-1:0]   window_last_row;
  } cfg_t;

  typedef struct packed {
    logic [CountWidth-1:0] red;
    logic [CountWidth-1:0] green;
    logic [CountWidth-1:0] blue;
  } tally_t;

endpackage

// ===== hdl/wcc_channels.sv =====
// ----------------------------------------------------------------------------
// wcc_channels
// Valid/ready channels of the classifier: pixel words in, frame results out.
// ----------------------------------------------------------------------------
interface wcc_pixel_if import wcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ValueWidth-1:0] red_value;
  logic [ValueWidth-1:0] green_value;
  logic [ValueWidth-1:0] blue_value;
  logic [RowWidth-1:0]   row_number;
  logic                  frame_end;

  modport source (
    output valid, red_value, green_value, blue_value, row_number, frame_end,
    input  ready
  );
  modport sink (
    input  valid, red_value, green_value, blue_value, row_number, frame_end,
    output ready
  );
endinterface

interface wcc_result_if import wcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ClassWidth-1:0] color_class;
  logic [CountWidth-1:0] red_count;
  logic [CountWidth-1:0] green_count;
  logic [CountWidth-1:0] blue_count;

  modport source (
    output valid, color_class, red_count, green_count, blue_count,
    input  ready
  );
  modport sink (
    input  valid, color_class, red_count, green_count, blue_count,
    output ready
  );
endinterface

// ===== hdl/wcc_regs.sv =====
// ----------------------------------------------------------------------------
// wcc_regs
// APB register file holding thresholds and the row window.
// ----------------------------------------------------------------------------
module wcc_regs import wcc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  reg_index_t index;
  logic       wr_en;

  assign index  = reg_index_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_threshold <= ChannelThresholdReset;
      cfg.count_threshold   <= CountThresholdReset;
      cfg.window_first_row  <= WindowFirstRowReset;
      cfg.window_last_row   <= WindowLastRowReset;
    end else if (wr_en) begin
      unique case (index)
        REG_CHANNEL_THRESHOLD: cfg.channel_threshold <= pwdata[ValueWidth-1:0];
        REG_COUNT_THRESHOLD:   cfg.count_threshold   <= pwdata[CountWidth-1:0];
        REG_WINDOW_FIRST_ROW:  cfg.window_first_row  <= pwdata[RowWidth-1:0];
        REG_WINDOW_LAST_ROW:   cfg.window_last_row   <= pwdata[RowWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_CHANNEL_THRESHOLD: prdata = ApbDataWidth'(cfg.channel_threshold);
      REG_COUNT_THRESHOLD:   prdata = ApbDataWidth'(cfg.count_threshold);
      REG_WINDOW_FIRST_ROW:  prdata = ApbDataWidth'(cfg.window_first_row);
      REG_WINDOW_LAST_ROW:   prdata = ApbDataWidth'(cfg.window_last_row);
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== hdl/wcc_tally.sv =====
// ----------------------------------------------------------------------------
// wcc_tally
// Pixel input register and per-channel saturating tallies; hands the final
// tallies of each frame to the classify stage.
// ----------------------------------------------------------------------------
module wcc_tally import wcc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  wcc_pixel_if.sink pix,
  output logic  frame_valid,
  input  logic  frame_ready,
  output tally_t frame_counts
);

  // input register
  logic                  pix_valid;
  logic [ValueWidth-1:0] red_value;
  logic [ValueWidth-1:0] green_value;
  logic [ValueWidth-1:0] blue_value;
  logic [RowWidth-1:0]   row_number;
  logic                  frame_end;

  tally_t tally;
  tally_t tally_next;
  logic   in_window;
  logic   pix_move;
  logic   frame_free;

  assign frame_free = !frame_valid || frame_ready;
  // a mid-frame word always drains; the last word needs room downstream
  assign pix_move   = pix_valid && (!frame_end || frame_free);
  assign pix.ready  = !pix_valid || pix_move;

  assign in_window = (row_number >= cfg.window_first_row) &&
                     (row_number <= cfg.window_last_row);

  always_comb begin
    tally_next = tally;
    if (in_window) begin
      if (red_value > cfg.channel_threshold && tally.red != TallyMax)
        tally_next.red = tally.red + 1'b1;
      if (green_value > cfg.channel_threshold && tally.green != TallyMax)
        tally_next.green = tally.green + 1'b1;
      if (blue_value > cfg.channel_threshold && tally.blue != TallyMax)
        tally_next.blue = tally.blue + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (pix.valid && pix.ready) begin
      pix_valid <= 1'b1;
    end else if (pix_move) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.valid && pix.ready) begin
      red_value   <= pix.red_value;
      green_value <= pix.green_value;
      blue_value  <= pix.blue_value;
      row_number  <= pix.row_number;
      frame_end   <= pix.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
    end else if (pix_move) begin
      tally <= frame_end ? '0 : tally_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (pix_move && frame_end) begin
      frame_valid <= 1'b1;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_move && frame_end) begin
      frame_counts <= tally_next;
    end
  end

endmodule

// ===== hdl/wcc_classify.sv =====
// ----------------------------------------------------------------------------
// wcc_classify
// Decides the frame's color class and holds the result word for the sink.
// ----------------------------------------------------------------------------
module wcc_classify import wcc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   frame_valid,
  output logic   frame_ready,
  input  tally_t frame_counts,
  wcc_result_if.source res
);

  color_class_t class_next;
  logic         res_valid;
  logic         robot;

  assign robot = (frame_counts.red   > cfg.count_threshold) &&
                 (frame_counts.green > cfg.count_threshold) &&
                 (frame_counts.blue  > cfg.count_threshold);

  always_comb begin
    priority if (robot) begin
      class_next = CLASS_ROBOT;
    end else if (frame_counts.red > frame_counts.green &&
                 frame_counts.red > frame_counts.blue) begin
      class_next = CLASS_RED;
    end else if (frame_counts.green > frame_counts.red &&
                 frame_counts.green > frame_counts.blue) begin
      class_next = CLASS_GREEN;
    end else if (frame_counts.blue > frame_counts.red &&
                 frame_counts.blue > frame_counts.green) begin
      class_next = CLASS_BLUE;
    end else begin
      class_next = CLASS_NONE;
    end
  end

  assign frame_ready = !res_valid || res.ready;
  assign res.valid   = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (frame_valid && frame_ready) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      res.color_class <= class_next;
      res.red_count   <= frame_counts.red;
      res.green_count <= frame_counts.green;
      res.blue_count  <= frame_counts.blue;
    end
  end

endmodule

// ===== hdl/window_color_classifier.sv =====
// ----------------------------------------------------------------------------
// window_color_classifier
// Counts bright pixels per channel in a row window and classifies each frame.
// ----------------------------------------------------------------------------
// Usage:
//   pix carries one pixel word per handshake (r, g, b, row, frame_end).
//   res carries one result word per frame: color class plus the three
//   channel tallies, taken after the frame_end pixel has been counted.
//   The APB port sets the channel threshold, the count threshold and the
//   first/last row of the window; write it only while the block is idle.
// Timing:
//   Throughput is one pixel word per clock unless a stall holds the
//   frame_end pixel. A frame_end pixel passes the input register, the
//   tally stage and the result register before its result word is valid.
// Reset (rst, synchronous): tallies cleared, both channels empty, registers
//   back to threshold 100, count threshold 100, window rows 55..63.
// Stall: a held result word plus one finished frame waiting behind it block
//   the next frame_end pixel; mid-frame pixels keep flowing until that pixel
//   is reached, then pix.ready drops.
// ----------------------------------------------------------------------------
module window_color_classifier import wcc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready,
  wcc_pixel_if.sink               pix,
  wcc_result_if.source            res
);

  cfg_t   cfg;
  logic   frame_valid;
  logic   frame_ready;
  tally_t frame_counts;

  // configuration registers
  wcc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pixel register + tallies; emits final tallies on frame_end
  wcc_tally u_tally (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pix          (pix),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame_counts (frame_counts)
  );

  // class decision + output register
  wcc_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame_counts (frame_counts),
    .res          (res)
  );

endmodule

// ===== hdl/wcc_checker.sv =====
// ----------------------------------------------------------------------------
// wcc_checker
// Port-level checks of the classifier result channel.
// ----------------------------------------------------------------------------
module wcc_checker import wcc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [ClassWidth-1:0] color_class,
  input logic [CountWidth-1:0] red_count,
  input logic [CountWidth-1:0] green_count,
  input logic [CountWidth-1:0] blue_count
);

  // nothing comes out in the cycle after reset
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(color_class) &&
      $stable(red_count) && $stable(green_count) && $stable(blue_count))
    else $error("stalled result word changed");

  // a channel class needs that channel strictly ahead
  assert property (@(posedge clk) disable iff (rst)
    res_valid && color_class == CLASS_RED |->
      red_count > green_count && red_count > blue_count)
    else $error("red class without red majority");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && color_class == CLASS_GREEN |->
      green_count > red_count && green_count > blue_count)
    else $error("green class without green majority");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && color_class == CLASS_BLUE |->
      blue_count > red_count && blue_count > green_count)
    else $error("blue class without blue majority");

endmodule

bind window_color_classifier wcc_checker u_wcc_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .color_class (res.color_class),
  .red_count   (res.red_count),
  .green_count (res.green_count),
  .blue_count  (res.blue_count)
);
